// ----- src/dte_pkg.sv -----
// ----------------------------------------------------------------------------
// Date to epoch days package
// Shared widths, constants, error codes and the month offset table.
// ----------------------------------------------------------------------------
package dte_pkg;

  localparam int DEF_BASE_YEAR = 1970;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DAYS_W  = 20;
  localparam int WDAY_W  = 3;
  localparam int TOTAL_W = 21;
  localparam int DOY_W   = 9;
  localparam int LEAPS_W = 11;

  localparam logic [DAYS_W-1:0] DAYS_MAX = '1;

  // Reciprocal of 25 for quotients below 1024.
  localparam logic [10:0] DIV25_MUL   = 11'd1311;
  localparam int          DIV25_SHIFT = 15;

  // Reciprocal of 7 for values below 2**TOTAL_W.
  localparam logic [23:0] MOD7_MUL   = 24'd9586981;
  localparam int          MOD7_SHIFT = 26;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_YEAR  = 2'd1,
    ERR_MONTH = 2'd2,
    ERR_DAY   = 2'd3
  } err_t;

  function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] month);
    logic [DOY_W-1:0] ofs;
    case (month)
      4'd1:    ofs = 9'd0;
      4'd2:    ofs = 9'd31;
      4'd3:    ofs = 9'd59;
      4'd4:    ofs = 9'd90;
      4'd5:    ofs = 9'd120;
      4'd6:    ofs = 9'd151;
      4'd7:    ofs = 9'd181;
      4'd8:    ofs = 9'd212;
      4'd9:    ofs = 9'd243;
      4'd10:   ofs = 9'd273;
      4'd11:   ofs = 9'd304;
      4'd12:   ofs = 9'd334;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// ----- src/date_to_epoch_days_weekday.sv -----
// ----------------------------------------------------------------------------
// Date to epoch days and weekday
// Throughput is one word per cycle through a five-stage pipeline while the
// output is not stalled.
// A stall on the output holds every stage in place.
// Reset clears the valid bits only; the data path has no reset.
// ----------------------------------------------------------------------------
module date_to_epoch_days_weekday
  import dte_pkg::*;
#(
  parameter int BASE_YEAR = DEF_BASE_YEAR
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [YEAR_W-1:0]  in_year_in,
  input  logic [MONTH_W-1:0] in_month_in,
  input  logic [DAY_W-1:0]   in_day_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DAYS_W-1:0]  out_epoch_days,
  output logic [WDAY_W-1:0]  out_weekday_index,
  output logic [1:0]         out_error_code
);

  localparam int BASE_LEAPS_I = (BASE_YEAR - 1) / 4 - (BASE_YEAR - 1) / 100
                              + (BASE_YEAR - 1) / 400;
  localparam logic [LEAPS_W-1:0] BASE_LEAPS = LEAPS_W'(BASE_LEAPS_I);
  localparam logic [YEAR_W-1:0]  BASE_Y     = YEAR_W'(BASE_YEAR);

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  assign en       = !(v5_r && out_stall);
  assign in_stall = !en;

  // Stage 1
  err_t              err1_nxt, err1_r;
  logic [YEAR_W-1:0] y1;
  logic [9:0]        q4m;
  logic [20:0]       pm, py;
  logic [5:0]        q100m_nxt, q100m_r, qy_nxt, qy_r;
  logic [9:0]        q4m_r;
  logic [YEAR_W-1:0] dy_nxt, dy_r, year_r;
  logic [DOY_W-1:0]  doy1_nxt, doy1_r;
  logic              late_r;

  always_comb begin
    if (in_year_in < BASE_Y) begin
      err1_nxt = ERR_YEAR;
    end else if (!(in_month_in inside {[4'd1:4'd12]})) begin
      err1_nxt = ERR_MONTH;
    end else if (in_day_in == '0) begin
      err1_nxt = ERR_DAY;
    end else begin
      err1_nxt = ERR_NONE;
    end
  end

  assign y1        = in_year_in - YEAR_W'(1);
  assign q4m       = y1[YEAR_W-1:2];
  assign pm        = 21'(q4m) * 21'(DIV25_MUL);
  assign py        = 21'(in_year_in[YEAR_W-1:2]) * 21'(DIV25_MUL);
  assign q100m_nxt = pm[DIV25_SHIFT+5:DIV25_SHIFT];
  assign qy_nxt    = py[DIV25_SHIFT+5:DIV25_SHIFT];
  assign dy_nxt    = in_year_in - BASE_Y;
  assign doy1_nxt  = month_offset(in_month_in) + DOY_W'(in_day_in);

  always_ff @(posedge clk) begin
    if (en) begin
      err1_r  <= err1_nxt;
      q4m_r   <= q4m;
      q100m_r <= q100m_nxt;
      qy_r    <= qy_nxt;
      dy_r    <= dy_nxt;
      year_r  <= in_year_in;
      doy1_r  <= doy1_nxt;
      late_r  <= in_month_in > 4'd2;
    end
  end

  // Stage 2
  err_t               err2_r;
  logic               cent;
  logic               leap;
  logic [LEAPS_W-1:0] leaps_nxt, leaps_r;
  logic [TOTAL_W-1:0] yd_nxt, yd_r;
  logic [DOY_W-1:0]   doy2_nxt, doy2_r;

  assign cent      = year_r == YEAR_W'(qy_r) * YEAR_W'(100);
  assign leap      = (year_r[1:0] == 2'd0) && (!cent || (qy_r[1:0] == 2'd0));
  assign leaps_nxt = LEAPS_W'(q4m_r) - LEAPS_W'(q100m_r) + LEAPS_W'(q100m_r[5:2])
                   - BASE_LEAPS;
  assign yd_nxt    = TOTAL_W'(dy_r) * TOTAL_W'(365);
  assign doy2_nxt  = doy1_r + DOY_W'(late_r && leap);

  always_ff @(posedge clk) begin
    if (en) begin
      err2_r  <= err1_r;
      leaps_r <= leaps_nxt;
      yd_r    <= yd_nxt;
      doy2_r  <= doy2_nxt;
    end
  end

  // Stage 3
  err_t               err3_r;
  logic [TOTAL_W-1:0] total_nxt, total_r;

  assign total_nxt = yd_r + TOTAL_W'(leaps_r) + TOTAL_W'(doy2_r) - TOTAL_W'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      err3_r  <= err2_r;
      total_r <= total_nxt;
    end
  end

  // Stage 4 and output stage; the weekday runs in the mod 7 unit alongside.
  err_t              err4_r, err5_r;
  logic [DAYS_W-1:0] days4_nxt, days4_r, days5_nxt, days5_r;

  assign days4_nxt = total_r[TOTAL_W-1] ? DAYS_MAX : total_r[DAYS_W-1:0];
  assign days5_nxt = (err4_r == ERR_NONE) ? days4_r : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      err4_r  <= err3_r;
      days4_r <= days4_nxt;
      err5_r  <= err4_r;
      days5_r <= days5_nxt;
    end
  end

  dte_mod7 u_mod7 (
    .clk   (clk),
    .en    (en),
    .x_i   (total_r),
    .clr_i (err3_r != ERR_NONE),
    .rem_o (out_weekday_index)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_valid      = v5_r;
  assign out_epoch_days = days5_r;
  assign out_error_code = err5_r;

endmodule

// ----- src/dte_mod7.sv -----
// ----------------------------------------------------------------------------
// Pipelined mod 7
// Two register stages: reciprocal quotient, then remainder with clear.
// ----------------------------------------------------------------------------
module dte_mod7
  import dte_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic [TOTAL_W-1:0] x_i,
  input  logic               clr_i,
  output logic [WDAY_W-1:0]  rem_o
);

  localparam int PROD_W = TOTAL_W + 24;
  localparam int Q_W    = PROD_W - MOD7_SHIFT;

  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     q_nxt, q_r;
  logic [TOTAL_W-1:0] x_r;
  logic               clr_r;
  logic [TOTAL_W-1:0] rem_full;
  logic [WDAY_W-1:0]  rem_nxt, rem_r;

  assign prod  = PROD_W'(x_i) * PROD_W'(MOD7_MUL);
  assign q_nxt = prod[PROD_W-1:MOD7_SHIFT];

  assign rem_full = x_r - TOTAL_W'(q_r) * TOTAL_W'(7);
  assign rem_nxt  = clr_r ? '0 : rem_full[WDAY_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      q_r   <= q_nxt;
      x_r   <= x_i;
      clr_r <= clr_i;
      rem_r <= rem_nxt;
    end
  end

  assign rem_o = rem_r;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Date to epoch days and weekday testbench
// Sends Gregorian dates through the pipeline with random idling on both sides
// and compares every result word with an in-bench calculation of the day
// count, the weekday and the error code. Covers the calendar edge cases, the
// error priority, random dates, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module testbench;
  import dte_pkg::*;

  localparam int unsigned BASE = DEF_BASE_YEAR;
  localparam int unsigned MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [WDAY_W-1:0] wday;
    err_t              err;
  } day_count_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [YEAR_W-1:0]  in_year_in = '0;
  logic [MONTH_W-1:0] in_month_in = '0;
  logic [DAY_W-1:0]   in_day_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DAYS_W-1:0]  out_epoch_days;
  logic [WDAY_W-1:0]  out_weekday_index;
  logic [1:0]         out_error_code;

  day_count_t day_counts_due[$];
  int         errors = 0;
  bit         tx_idle = 1'b1;
  bit         rx_idle = 1'b1;
  int         hold_request = 0;

  date_to_epoch_days_weekday i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_year_in        (in_year_in),
    .in_month_in       (in_month_in),
    .in_day_in         (in_day_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_epoch_days    (out_epoch_days),
    .out_weekday_index (out_weekday_index),
    .out_error_code    (out_error_code)
  );

  always #5 clk = ~clk;

  function automatic int unsigned leap_count(input int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  function automatic day_count_t date_to_day_count(input logic [YEAR_W-1:0] year,
                                                   input logic [MONTH_W-1:0] month,
                                                   input logic [DAY_W-1:0] day);
    day_count_t  r;
    int unsigned y;
    int unsigned doy;
    int unsigned total;
    r.days = '0;
    r.wday = '0;
    r.err  = ERR_NONE;
    y = 32'(year);
    if (y < BASE) begin
      r.err = ERR_YEAR;
    end else if (month < 1 || month > 12) begin
      r.err = ERR_MONTH;
    end else if (day < 1) begin
      r.err = ERR_DAY;
    end else begin
      doy = 32'(day);
      for (int m = 1; m < month; m++) doy += MONTH_DAYS[m];
      if (month > 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0)) doy += 1;
      total = 365 * (y - BASE) + leap_count(y - 1) - leap_count(BASE - 1) + doy - 1;
      r.wday = WDAY_W'(total % 7);
      r.days = (total > DAYS_MAX) ? DAYS_MAX : DAYS_W'(total);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    day_count_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (day_counts_due.size() == 0) begin
        report_mismatch("unexpected word, pending count", 0, 1);
      end else begin
        want = day_counts_due.pop_front();
        if (out_epoch_days !== want.days) begin
          report_mismatch("epoch_days", int'(want.days), int'(out_epoch_days));
        end
        if (out_weekday_index !== want.wday) begin
          report_mismatch("weekday_index", int'(want.wday), int'(out_weekday_index));
        end
        if (out_error_code !== want.err) begin
          report_mismatch("error_code", int'(want.err), int'(out_error_code));
        end
      end
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (out_valid && !out_stall) begin
        stall_left = rx_idle ? $urandom_range(0, 4) : 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_date(input logic [YEAR_W-1:0] year, input logic [MONTH_W-1:0] month,
                           input logic [DAY_W-1:0] day);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_year_in  <= year;
    in_month_in <= month;
    in_day_in   <= day;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    day_counts_due.push_back(date_to_day_count(year, month, day));
  endtask

  task automatic send_random_date();
    if ($urandom_range(0, 99) < 85) begin
      send_date(YEAR_W'($urandom_range(BASE, 4095)), MONTH_W'($urandom_range(1, 12)),
                DAY_W'($urandom_range(1, 31)));
    end else begin
      send_date(YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (day_counts_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_calendar_dates();
    send_date(12'd1970, 4'd1, 5'd1);
    send_date(12'd1972, 4'd2, 5'd29);
    send_date(12'd1972, 4'd3, 5'd1);
    send_date(12'd2000, 4'd3, 5'd1);
    send_date(12'd2100, 4'd3, 5'd1);
    send_date(12'd2024, 4'd2, 5'd31);
    send_date(12'd4095, 4'd12, 5'd31);
    for (int m = 1; m <= 12; m++) send_date(12'd2001, MONTH_W'(m), 5'd31);
  endtask

  task automatic test_error_codes();
    send_date(12'd0, 4'd0, 5'd0);
    send_date(12'd1969, 4'd13, 5'd0);
    send_date(12'd1970, 4'd0, 5'd5);
    send_date(12'd2000, 4'd15, 5'd0);
    send_date(12'd2000, 4'd6, 5'd0);
  endtask

  task automatic test_random_dates();
    for (int stretch = 0; stretch < 10; stretch++) begin
      tx_idle = 1'($urandom_range(0, 1));
      rx_idle = 1'($urandom_range(0, 1));
      repeat (90) send_random_date();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_output_backpressure();
    tx_idle = 1'b0;
    hold_request = 80;
    repeat (40) send_random_date();
    tx_idle = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (5) begin
      repeat (8) send_random_date();
      wait_drained();
    end
  endtask

  initial begin : run_tests
    int waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_calendar_dates();
    test_error_codes();
    test_random_dates();
    test_output_backpressure();
    test_drain_pause();
    in_valid <= 1'b0;
    waited = 0;
    while (day_counts_due.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (day_counts_due.size() != 0) begin
      report_mismatch("leftover pending count", 0, day_counts_due.size());
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("date_to_epoch_days_weekday test passed");
    end else begin
      $display("date_to_epoch_days_weekday test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("date_to_epoch_days_weekday test failed");
    $finish;
  end

endmodule
